// File: rtl/scac_pkg.sv
// ---------------------------------------------------------------------------
// scac_pkg
// Shared types and constants for the set-associative cache tag lookup.
// ---------------------------------------------------------------------------
package scac_pkg;

  localparam int ADDR_IN_W  = 32;
  localparam int TAG_W      = 32;
  localparam int WAY_OUT_W  = 3;
  localparam int SET_OUT_W  = 6;
  localparam int TOTAL_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LINE_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SET_INDEX   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS        = 2'd2;

  localparam logic [3:0] LINE_OFFSET_RST = 4'd4;
  localparam logic [2:0] SET_INDEX_RST   = 3'd2;
  localparam logic [3:0] WAYS_RST        = 4'd2;
  localparam logic [3:0] MAX_OFFSET_BITS = 4'd12;

  // way index wide enough for the largest supported associativity (32)
  typedef logic [4:0] way_idx_t;

  typedef struct packed {
    logic     hit;
    way_idx_t way;
  } match_t;

endpackage

// File: rtl/scac_in_if.sv
// ---------------------------------------------------------------------------
// scac_in_if
// Address channel: one byte address per transaction.
// ---------------------------------------------------------------------------
interface scac_in_if;
  logic                           valid;
  logic                           ready;
  logic [scac_pkg::ADDR_IN_W-1:0] address;

  modport source (output valid, output address, input ready);
  modport sink   (input valid, input address, output ready);
endinterface

// File: rtl/scac_out_if.sv
// ---------------------------------------------------------------------------
// scac_out_if
// Lookup result channel: hit/miss, way, set, tag and running totals.
// ---------------------------------------------------------------------------
interface scac_out_if;
  logic                           valid;
  logic                           ready;
  logic                           hit;
  logic [scac_pkg::WAY_OUT_W-1:0] way_used;
  logic [scac_pkg::SET_OUT_W-1:0] set_number;
  logic [scac_pkg::TAG_W-1:0]     line_tag;
  logic [scac_pkg::TOTAL_W-1:0]   hit_total;
  logic [scac_pkg::TOTAL_W-1:0]   miss_total;

  modport source (output valid, output hit, output way_used, output set_number,
                  output line_tag, output hit_total, output miss_total, input ready);
  modport sink   (input valid, input hit, input way_used, input set_number,
                  input line_tag, input hit_total, input miss_total, output ready);
endinterface

// File: rtl/scac_cfg_if.sv
// ---------------------------------------------------------------------------
// scac_cfg_if
// Configuration write channel: register index and write data.
// ---------------------------------------------------------------------------
interface scac_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [scac_pkg::CFG_IDX_W-1:0]  index;
  logic [scac_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/scac_tag_ram.sv
// ---------------------------------------------------------------------------
// scac_tag_ram
// Single-port-write, single-read synchronous RAM holding one set per row.
// ---------------------------------------------------------------------------
module scac_tag_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/scac_way_match.sv
// ---------------------------------------------------------------------------
// scac_way_match
// Parallel tag compare over one set, FIFO victim choice and row update.
// ---------------------------------------------------------------------------
module scac_way_match #(
  parameter int MAX_WAYS = 8,
  parameter int PTR_W    = 3,
  parameter int CNT_W    = 4
) (
  input  logic [MAX_WAYS*scac_pkg::TAG_W-1:0] tags,
  input  logic [MAX_WAYS-1:0]                 valid,
  input  logic [PTR_W-1:0]                    ptr,
  input  logic [scac_pkg::TAG_W-1:0]          tag,
  input  logic [CNT_W-1:0]                    ways,
  output scac_pkg::match_t                    match,
  output logic [MAX_WAYS*scac_pkg::TAG_W-1:0] tags_new,
  output logic [MAX_WAYS-1:0]                 valid_new,
  output logic [PTR_W-1:0]                    ptr_new
);

  localparam int TW = scac_pkg::TAG_W;

  logic                hit;
  scac_pkg::way_idx_t  hit_way;
  logic [PTR_W-1:0]    fill;
  logic [CNT_W-1:0]    fill_inc;

  // lowest matching way wins: scan from the top down
  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if ((CNT_W'(w) < ways) && valid[w] && (tags[w*TW +: TW] == tag)) begin
        hit     = 1'b1;
        hit_way = scac_pkg::way_idx_t'(w);
      end
    end
  end

  // a stale pointer past the current associativity restarts at way 0
  always_comb begin
    fill     = (CNT_W'(ptr) >= ways) ? '0 : ptr;
    fill_inc = CNT_W'(fill) + CNT_W'(1);
    ptr_new  = (fill_inc >= ways) ? '0 : PTR_W'(fill_inc);
  end

  always_comb begin
    valid_new           = valid;
    valid_new[fill]     = 1'b1;
    tags_new            = tags;
    tags_new[fill*TW +: TW] = tag;
  end

  always_comb begin
    match.hit = hit;
    match.way = hit ? hit_way : scac_pkg::way_idx_t'(fill);
  end

endmodule

// File: rtl/set_assoc_cache_fifo_lookup.sv
// ---------------------------------------------------------------------------
// set_assoc_cache_fifo_lookup
// Tag store of a set-associative cache with round-robin replacement.
// Flow: an accepted address reads its set's RAM row; the lookup state then
// compares and, on a miss, writes back the same row, waiting while an earlier
// result is still held on the output. No new address is accepted until the
// lookup finishes.
// Reset: registers reset to their defaults, then a clearing pass over all
// MAX_SETS rows zeroes valid bits and fill pointers; addresses are held off meanwhile.
// ---------------------------------------------------------------------------
module set_assoc_cache_fifo_lookup #(
  parameter int MAX_SETS   = 64,
  parameter int MAX_WAYS   = 8,
  parameter int ADDR_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  scac_in_if.sink           in_chan,
  scac_out_if.source        out_chan,
  scac_cfg_if.sink          cfg_chan
);

  localparam int TW     = scac_pkg::TAG_W;
  localparam int AW     = scac_pkg::ADDR_IN_W;
  localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int PTR_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int CNT_W  = $clog2(MAX_WAYS + 1);
  localparam int TAGS_W = MAX_WAYS * TW;
  localparam int ROW_W  = PTR_W + MAX_WAYS + TAGS_W;
  // largest set-bit count with 2^bits <= MAX_SETS
  localparam int SB_MAX = ((1 << $clog2(MAX_SETS)) == MAX_SETS) ?
                          $clog2(MAX_SETS) : $clog2(MAX_SETS) - 1;
  localparam logic [AW-1:0] ADDR_MASK = (ADDR_WIDTH >= AW) ? {AW{1'b1}} :
                                        AW'((64'd1 << ADDR_WIDTH) - 64'd1);

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_LOOKUP = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [SET_W-1:0] clr_idx_r, clr_idx_nxt;

  logic [3:0] lob_r;
  logic [2:0] sib_r;
  logic [3:0] ways_r;

  logic [SET_W-1:0]              set_r;
  logic [scac_pkg::SET_OUT_W-1:0] set_num_r;
  logic [TW-1:0]                 tag_r;

  logic                            out_valid_r, out_valid_nxt;
  logic                            out_hit_r;
  logic [scac_pkg::WAY_OUT_W-1:0]  out_way_r;
  logic [scac_pkg::SET_OUT_W-1:0]  out_set_r;
  logic [TW-1:0]                   out_tag_r;
  logic [scac_pkg::TOTAL_W-1:0]    hit_total_r, hit_total_nxt;
  logic [scac_pkg::TOTAL_W-1:0]    miss_total_r, miss_total_nxt;

  logic             in_fire;
  logic             finish;
  logic [3:0]       eff_ob;
  logic [3:0]       eff_sb;
  logic [CNT_W-1:0] eff_ways;
  logic [AW-1:0]    addr;
  logic [AW-1:0]    block;
  logic [AW-1:0]    set_full;
  logic [AW-1:0]    tag_full;

  logic             ram_we;
  logic [SET_W-1:0] ram_waddr;
  logic [ROW_W-1:0] ram_wdata;
  logic [ROW_W-1:0] rd_row;

  scac_pkg::match_t    match;
  logic [TAGS_W-1:0]   tags_new;
  logic [MAX_WAYS-1:0] valid_new;
  logic [PTR_W-1:0]    ptr_new;

  // ---------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lob_r  <= scac_pkg::LINE_OFFSET_RST;
      sib_r  <= scac_pkg::SET_INDEX_RST;
      ways_r <= scac_pkg::WAYS_RST;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        scac_pkg::REG_LINE_OFFSET: lob_r  <= cfg_chan.data;
        scac_pkg::REG_SET_INDEX:   sib_r  <= cfg_chan.data[2:0];
        scac_pkg::REG_WAYS:        ways_r <= cfg_chan.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    eff_ob = (lob_r > scac_pkg::MAX_OFFSET_BITS) ? scac_pkg::MAX_OFFSET_BITS : lob_r;
    eff_sb = ({1'b0, sib_r} > 4'(SB_MAX)) ? 4'(SB_MAX) : {1'b0, sib_r};
    if (ways_r == 4'd0) begin
      eff_ways = CNT_W'(1);
    end else if ({2'b00, ways_r} > 6'(MAX_WAYS)) begin
      eff_ways = CNT_W'(MAX_WAYS);
    end else begin
      eff_ways = CNT_W'(ways_r);
    end
  end

  // ---------------------------------------------------------------------
  // address split
  // ---------------------------------------------------------------------
  always_comb begin
    addr     = in_chan.address & ADDR_MASK;
    block    = addr >> eff_ob;
    set_full = block & ((AW'(1) << eff_sb) - AW'(1));
    tag_full = block >> eff_sb;
  end

  // ---------------------------------------------------------------------
  // control
  // ---------------------------------------------------------------------
  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign finish        = (state_r == ST_LOOKUP) && (!out_valid_r || out_chan.ready);

  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    case (state_r)
      ST_CLEAR: begin
        clr_idx_nxt = clr_idx_r + SET_W'(1);
        if (clr_idx_r == SET_W'(MAX_SETS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (finish) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_idx_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      set_r     <= SET_W'(set_full);
      set_num_r <= set_full[scac_pkg::SET_OUT_W-1:0];
      tag_r     <= tag_full[TW-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // set RAM: {fill pointer, valid bits, tags}
  // ---------------------------------------------------------------------
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = set_r;
    ram_wdata = {ptr_new, valid_new, tags_new};
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx_r;
      ram_wdata = '0;
    end else if (finish && !match.hit) begin
      ram_we = 1'b1;
    end
  end

  scac_tag_ram #(
    .DATA_W (ROW_W),
    .DEPTH  (MAX_SETS),
    .ADDR_W (SET_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (in_fire),
    .rd_addr (SET_W'(set_full)),
    .rd_data (rd_row)
  );

  scac_way_match #(
    .MAX_WAYS (MAX_WAYS),
    .PTR_W    (PTR_W),
    .CNT_W    (CNT_W)
  ) u_match (
    .tags      (rd_row[TAGS_W-1:0]),
    .valid     (rd_row[TAGS_W +: MAX_WAYS]),
    .ptr       (rd_row[ROW_W-1 -: PTR_W]),
    .tag       (tag_r),
    .ways      (eff_ways),
    .match     (match),
    .tags_new  (tags_new),
    .valid_new (valid_new),
    .ptr_new   (ptr_new)
  );

  // ---------------------------------------------------------------------
  // totals and result register
  // ---------------------------------------------------------------------
  always_comb begin
    hit_total_nxt  = hit_total_r;
    miss_total_nxt = miss_total_r;
    if (finish) begin
      if (match.hit) begin
        if (hit_total_r != '1) hit_total_nxt = hit_total_r + 1'b1;
      end else begin
        if (miss_total_r != '1) miss_total_nxt = miss_total_r + 1'b1;
      end
    end
    out_valid_nxt = out_valid_r;
    if (finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      hit_total_r  <= '0;
      miss_total_r <= '0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      hit_total_r  <= hit_total_nxt;
      miss_total_r <= miss_total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_hit_r <= match.hit;
      out_way_r <= match.way[scac_pkg::WAY_OUT_W-1:0];
      out_set_r <= set_num_r;
      out_tag_r <= tag_r;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.hit        = out_hit_r;
  assign out_chan.way_used   = out_way_r;
  assign out_chan.set_number = out_set_r;
  assign out_chan.line_tag   = out_tag_r;
  assign out_chan.hit_total  = hit_total_r;
  assign out_chan.miss_total = miss_total_r;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  a_fire_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_LOOKUP))
    else $error("accepted address did not enter lookup");

  a_result_from_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_LOOKUP))
    else $error("result appeared without a lookup");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !in_chan.ready)
    else $error("address accepted during clearing pass");

  a_totals_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ((hit_total_r >= $past(hit_total_r)) &&
                      (miss_total_r >= $past(miss_total_r))))
    else $error("hit or miss total decreased");

endmodule

// File: verif/scac_tb_pkg.sv
// ---------------------------------------------------------------------------
// scac_tb_pkg
// Lookup predictor and result checker for the cache tag store testbench.
// Tracks valid bits, tags, fill pointers and totals, and queues the expected
// lookup result for every accepted address transaction.
// ---------------------------------------------------------------------------
package scac_tb_pkg;

  import scac_pkg::*;

  localparam int TB_SETS      = 64;
  localparam int TB_WAYS      = 8;

  typedef struct packed {
    logic                 hit;
    logic [WAY_OUT_W-1:0] way_used;
    logic [SET_OUT_W-1:0] set_number;
    logic [TAG_W-1:0]     line_tag;
    logic [TOTAL_W-1:0]   hit_total;
    logic [TOTAL_W-1:0]   miss_total;
  } lookup_t;

  class lookup_checker;
    logic [3:0]         offset_reg;
    logic [2:0]         set_reg;
    logic [3:0]         ways_reg;
    bit                 line_valid [TB_SETS][TB_WAYS];
    logic [TAG_W-1:0]   line_tags [TB_SETS][TB_WAYS];
    int unsigned        fill_ptr [TB_SETS];
    logic [TOTAL_W-1:0] hits;
    logic [TOTAL_W-1:0] misses;
    lookup_t            lookups_due [$];
    int                 errors;

    function new();
      offset_reg = LINE_OFFSET_RST;
      set_reg    = SET_INDEX_RST;
      ways_reg   = WAYS_RST;
      foreach (line_valid[s, w]) begin
        line_valid[s][w] = 1'b0;
        line_tags[s][w]  = '0;
      end
      foreach (fill_ptr[s]) fill_ptr[s] = 0;
      hits   = '0;
      misses = '0;
      errors = 0;
    endfunction

    function int unsigned eff_offset();
      return (offset_reg > MAX_OFFSET_BITS) ? MAX_OFFSET_BITS : offset_reg;
    endfunction

    // sets are capped at 64, so 7 index bits fall back to 6
    function int unsigned eff_set_bits();
      return (set_reg > 3'd6) ? 6 : set_reg;
    endfunction

    // bits below the tag: line offset plus set index
    function int unsigned index_span();
      return eff_offset() + eff_set_bits();
    endfunction

    function int pending();
      return lookups_due.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_LINE_OFFSET: offset_reg = data;
        REG_SET_INDEX:   set_reg = data[2:0];
        REG_WAYS:        ways_reg = data;
        default: ;
      endcase
    endfunction

    function void note_address(logic [ADDR_IN_W-1:0] addr);
      logic [31:0] block;
      logic [31:0] set_idx;
      logic [31:0] tag;
      int unsigned ways;
      int unsigned sb;
      int unsigned p;
      lookup_t     res;
      sb    = eff_set_bits();
      ways  = (ways_reg == 0) ? 1 : ((ways_reg > TB_WAYS) ? TB_WAYS : ways_reg);
      block = addr >> eff_offset();
      set_idx = block & ((32'd1 << sb) - 32'd1);
      tag   = block >> sb;
      res   = '0;
      for (int w = 0; w < ways; w++) begin
        if (line_valid[set_idx][w] && line_tags[set_idx][w] == tag) begin
          res.hit      = 1'b1;
          res.way_used = WAY_OUT_W'(w);
          break;
        end
      end
      if (res.hit) begin
        hits = (hits == '1) ? hits : hits + 1'b1;
      end else begin
        // a pointer left beyond the way count by a register change restarts at 0
        p = (fill_ptr[set_idx] >= ways) ? 0 : fill_ptr[set_idx];
        line_valid[set_idx][p] = 1'b1;
        line_tags[set_idx][p]  = tag;
        fill_ptr[set_idx]      = (p + 1 >= ways) ? 0 : p + 1;
        res.way_used = WAY_OUT_W'(p);
        misses = (misses == '1) ? misses : misses + 1'b1;
      end
      res.set_number = SET_OUT_W'(set_idx);
      res.line_tag   = tag;
      res.hit_total  = hits;
      res.miss_total = misses;
      lookups_due.push_back(res);
    endfunction

    function void field_check(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_lookup(lookup_t got);
      lookup_t want;
      if (lookups_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %0h", $time, got);
        return;
      end
      want = lookups_due.pop_front();
      field_check("hit", want.hit, got.hit);
      field_check("way_used", want.way_used, got.way_used);
      field_check("set_number", want.set_number, got.set_number);
      field_check("line_tag", want.line_tag, got.line_tag);
      field_check("hit_total", want.hit_total, got.hit_total);
      field_check("miss_total", want.miss_total, got.miss_total);
    endfunction
  endclass

endpackage

// File: verif/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Testbench for the set-associative cache tag lookup. Directed accesses cover
// hits, evictions, pointer wrap and out-of-range register values; random
// phases then reuse small address pools under several cache geometries, with
// random stalls on both channels and one long hold on the result side.
// ---------------------------------------------------------------------------
module tb_top;

  import scac_pkg::*;
  import scac_tb_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 300;
  localparam int PHASE_ITEMS = 180;
  localparam int NUM_PHASES  = 10;
  localparam int POOL_SIZE   = 16;

  logic clk;
  logic rst_n;

  scac_in_if  in_if ();
  scac_out_if out_if ();
  scac_cfg_if cfg_if ();

  set_assoc_cache_fifo_lookup uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  lookup_checker lookups = new();

  bit          idle_en = 1'b1;
  bit          long_hold_req = 1'b0;
  int unsigned cycles = 0;
  logic [31:0] pool [POOL_SIZE];

  logic [31:0] opening_addrs [9] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0004,
                                     32'h0000_0040, 32'h0000_0080, 32'h0000_0000,
                                     32'hFFFF_FFF0, 32'h5555_5555, 32'hAAAA_AAAA};

  // geometry per random phase: offset bits, set bits, ways
  int phase_off [NUM_PHASES] = '{4, 0, 12, 15, 6, 2, 13, 0, 5, 0};
  int phase_set [NUM_PHASES] = '{2, 0, 6, 7, 3, 1, 5, 0, 4, 6};
  int phase_way [NUM_PHASES] = '{2, 1, 8, 15, 0, 4, 3, 0, 8, 7};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin : monitor
    lookup_t got;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        got.hit        = out_if.hit;
        got.way_used   = out_if.way_used;
        got.set_number = out_if.set_number;
        got.line_tag   = out_if.line_tag;
        got.hit_total  = out_if.hit_total;
        got.miss_total = out_if.miss_total;
        lookups.check_lookup(got);
      end
      if (in_if.valid && in_if.ready) lookups.note_address(in_if.address);
      if (cfg_if.valid && cfg_if.ready) lookups.write_reg(cfg_if.index, cfg_if.data);
    end
  end

  // result side: random stall bursts, plus one long hold on request
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = LONG_HOLD - 1;
        out_if.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 10);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // all driving tasks start and end on a falling edge
  task automatic send_addr(input logic [ADDR_IN_W-1:0] addr);
    int gap;
    gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.address <= addr;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (lookups.pending() > 0) @(negedge clk);
  endtask

  task automatic write_one(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_config(input int off, input int sets, input int ways);
    write_one(REG_LINE_OFFSET, CFG_DATA_W'(off));
    write_one(REG_SET_INDEX, CFG_DATA_W'(sets));
    write_one(REG_WAYS, CFG_DATA_W'(ways));
    cfg_if.valid <= 1'b0;
  endtask

  // mostly pool addresses (half share one set) so hits and evictions are common
  task automatic run_phase(input int n);
    logic [31:0] line_mask;
    logic [31:0] low_mask;
    logic [31:0] addr;
    line_mask = (32'd1 << lookups.eff_offset()) - 32'd1;
    low_mask  = (32'd1 << lookups.index_span()) - 32'd1;
    pool[0] = $urandom;
    for (int i = 1; i < POOL_SIZE; i++)
      pool[i] = (i < POOL_SIZE / 2) ? ((pool[0] & low_mask) | ($urandom & ~low_mask))
                                    : $urandom;
    repeat (n) begin
      if ($urandom_range(0, 9) < 7)
        addr = pool[$urandom_range(0, POOL_SIZE - 1)] ^ ($urandom & line_mask);
      else
        addr = $urandom;
      send_addr(addr);
    end
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.address = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // default geometry: hits, eviction in set 0, field extremes
    foreach (opening_addrs[i]) send_addr(opening_addrs[i]);
    drain();
    // one set, byte lines: advance set 0's fill pointer to 5
    set_config(0, 0, 8);
    for (int a = 1; a <= 5; a++) send_addr(a);
    send_addr(1);
    drain();
    // fewer ways than the pointer value
    set_config(0, 0, 3);
    send_addr(9);
    drain();
    // zero ways acts as one
    set_config(0, 0, 0);
    send_addr(10);
    send_addr(10);
    drain();
    // ways above the maximum clamp to eight
    set_config(0, 0, 15);
    send_addr(1);
    send_addr(9);
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == 7)
        set_config($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15));
      else
        set_config(phase_off[ph], phase_set[ph], phase_way[ph]);
      if (ph == 2) long_hold_req = 1'b1;
      if (ph == NUM_PHASES - 1) idle_en = 1'b0;
      run_phase(PHASE_ITEMS);
    end

    repeat (8) @(negedge clk);
    if (lookups.errors == 0 && lookups.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      if (lookups.pending() > 0)
        $display("%0t: %0d lookups expected, none returned", $time, lookups.pending());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
